### rtl/core/lff_pkg.sv
`timescale 1ns / 1ps

package lff_pkg;

    // Field widths
    localparam int unsigned MM_W   = 16;
    localparam int unsigned SCAN_W = 11;
    localparam int unsigned TRIG_W = 17;   // positive Q16 magnitude, 65536 = 1.0
    localparam int unsigned PROD_W = MM_W + TRIG_W;

    typedef logic [MM_W-1:0]   t_mm;
    typedef logic [SCAN_W-1:0] t_scan;
    typedef logic [TRIG_W-1:0] t_trig;
    typedef logic [PROD_W-1:0] t_prod;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCAN_BEAMS  = 2'd0,
        CFG_MAX_RANGE   = 2'd1,
        CFG_MIN_RANGE   = 2'd2,
        CFG_NO_OBSTACLE = 2'd3
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam t_scan RST_SCAN_BEAMS  = 11'd1024;
    localparam t_mm   RST_MAX_RANGE   = 16'd25000;
    localparam t_mm   RST_MIN_RANGE   = 16'd50;
    localparam t_mm   RST_NO_OBSTACLE = 16'd10000;

    // Trolley geometry, limits pre-scaled to Q16
    localparam t_prod FRONT_LIM_Q16 = t_prod'(266)  << 16;
    localparam t_prod SIDE_LIM_Q16  = t_prod'(400)  << 16;
    localparam t_prod BOX_LIM_Q16   = t_prod'(2266) << 16;

    // Beam angle step and folding constants in Q30
    localparam logic [63:0] STEP_Q30    = 64'd6184323;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

    // Per-beam angle region flags
    typedef struct packed {
        logic front;   // footprint uses the front edge
        logic box;     // forward box test applies
        logic corr;    // side corridor test applies
        logic last;    // last beam of the scan
    } t_region;

    // Stage result handed to the running minimum
    typedef struct packed {
        t_mm  filt;
        logic hit;
        t_mm  tod;
        logic last;
    } t_proj;

    // sin of a Q30 angle, Taylor series to x^13 with quadrant folding,
    // rounded to Q16. Non-positive results come back as 0.
    // Used only at elaboration to fill the trig ROM.
    function automatic t_trig trig_q16(input logic [63:0] a_in);
        logic [63:0]        a;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        s;
        logic signed [63:0] sum;
        logic               neg;
        a   = a_in % TWO_PI_Q30;
        neg = 1'b0;
        if (a >= PI_Q30) begin
            neg = 1'b1;
            a   = a - PI_Q30;
        end
        if (a > HALF_PI_Q30) begin
            a = PI_Q30 - a;
        end
        x    = a;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 6; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            unique case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if (k[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        s = (unsigned'(sum) + 64'd8192) >> 14;
        if (s > 64'd65536) begin
            s = 64'd65536;
        end
        return neg ? t_trig'(0) : s[TRIG_W-1:0];
    endfunction

endpackage

### rtl/core/lff_in_if.sv
`timescale 1ns / 1ps

interface lff_in_if;
    logic             valid;
    logic             ready;
    lff_pkg::t_mm     range_mm;
    logic             range_bad;

    modport source (output valid, output range_mm, output range_bad, input ready);
    modport sink   (input valid, input range_mm, input range_bad, output ready);
endinterface

### rtl/core/lff_out_if.sv
`timescale 1ns / 1ps

interface lff_out_if;
    logic             valid;
    logic             ready;
    lff_pkg::t_mm     filtered_mm;
    lff_pkg::t_mm     obstacle_mm;
    logic             scan_end;

    modport source (output valid, output filtered_mm, output obstacle_mm, output scan_end,
                    input ready);
    modport sink   (input valid, input filtered_mm, input obstacle_mm, input scan_end,
                    output ready);
endinterface

### rtl/core/lff_beam_index.sv
`timescale 1ns / 1ps

module lff_beam_index #(
    parameter int unsigned MAX_BEAMS     = 1024,
    parameter int unsigned FOOTPRINT_IDX = 170,
    parameter int unsigned BOX_EDGE_IDX  = 30
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  lff_pkg::t_scan                i_scan_beams,
    output logic [$clog2(MAX_BEAMS)-1:0]  o_offset,
    output lff_pkg::t_region              o_region
);

    localparam int unsigned AW = $clog2(MAX_BEAMS);
    localparam int unsigned NW = $clog2(MAX_BEAMS + 1);
    localparam int unsigned CW = (NW > lff_pkg::SCAN_W) ? NW : lff_pkg::SCAN_W;

    logic [AW-1:0] r_beam_count;
    logic [AW-1:0] n_beam_count;
    logic [CW-1:0] sb;
    logic [CW-1:0] n_len;
    logic [CW-1:0] ctr;
    logic [CW-1:0] cnt;
    logic [CW-1:0] ofs;
    logic          lower;
    logic          last;

    // Effective scan length, centre and offset from the centre
    always_comb begin
        sb = CW'(i_scan_beams);
        if (sb < CW'(2)) begin
            n_len = CW'(2);
        end else if (sb > CW'(MAX_BEAMS)) begin
            n_len = CW'(MAX_BEAMS);
        end else begin
            n_len = sb;
        end
        ctr   = n_len >> 1;
        cnt   = CW'(r_beam_count);
        lower = cnt < ctr;
        ofs   = lower ? (ctr - cnt) : (cnt - ctr);
        last  = cnt >= (n_len - CW'(1));
    end

    // Region flags; edges differ by one beam on either side of the centre
    always_comb begin
        o_region.front = lower ? (ofs <= CW'(FOOTPRINT_IDX)) : (ofs < CW'(FOOTPRINT_IDX));
        o_region.box   = lower ? (ofs < CW'(BOX_EDGE_IDX)) : (ofs <= CW'(BOX_EDGE_IDX));
        o_region.corr  = ofs <= CW'(FOOTPRINT_IDX);
        o_region.last  = last;
        o_offset       = ofs[AW-1:0];
    end

    // Beam counter, wraps on the last beam
    always_comb begin
        n_beam_count = last ? '0 : (r_beam_count + AW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_count <= '0;
        end else if (i_accept) begin
            r_beam_count <= n_beam_count;
        end
    end

endmodule

### rtl/core/lff_trig_rom.sv
`timescale 1ns / 1ps

module lff_trig_rom #(
    parameter int unsigned MAX_BEAMS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [$clog2(MAX_BEAMS)-1:0]  i_addr,
    output lff_pkg::t_trig                o_sin,
    output lff_pkg::t_trig                o_cos
);

    typedef lff_pkg::t_trig t_rom [MAX_BEAMS];

    // Table of sin or cos for every beam offset
    function automatic t_rom build_rom(input logic want_cos);
        t_rom        rom;
        logic [63:0] ang;
        for (int k = 0; k < MAX_BEAMS; k++) begin
            ang = 64'(k) * lff_pkg::STEP_Q30;
            if (want_cos) begin
                ang = ang + lff_pkg::HALF_PI_Q30;
            end
            rom[k] = lff_pkg::trig_q16(ang);
        end
        return rom;
    endfunction

    localparam t_rom SIN_ROM = build_rom(1'b0);
    localparam t_rom COS_ROM = build_rom(1'b1);

    lff_pkg::t_trig r_sin;
    lff_pkg::t_trig r_cos;

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= SIN_ROM[i_addr];
            r_cos <= COS_ROM[i_addr];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

### rtl/core/lff_mask_proj.sv
`timescale 1ns / 1ps

module lff_mask_proj (
    input  lff_pkg::t_mm      i_raw,
    input  logic              i_bad,
    input  lff_pkg::t_region  i_region,
    input  lff_pkg::t_trig    i_sin,
    input  lff_pkg::t_trig    i_cos,
    input  lff_pkg::t_mm      i_max_range,
    input  lff_pkg::t_mm      i_min_range,
    output lff_pkg::t_proj    o_proj
);

    logic           valid;
    lff_pkg::t_mm   ld;
    lff_pkg::t_prod p_cos;
    lff_pkg::t_prod p_sin;
    logic           cos_pos;
    logic           sin_pos;
    logic           front_in;
    logic           side_in;
    logic           box_in;
    logic           masked;
    logic [lff_pkg::PROD_W:0] rnd;

    // Validity and clamp
    always_comb begin
        valid = !i_bad && (i_raw <= i_max_range) && (i_raw >= i_min_range);
        ld    = valid ? i_raw : i_max_range;
    end

    // Projections onto the forward and side axes
    always_comb begin
        p_cos   = lff_pkg::t_prod'(ld) * lff_pkg::t_prod'(i_cos);
        p_sin   = lff_pkg::t_prod'(ld) * lff_pkg::t_prod'(i_sin);
        cos_pos = i_cos != '0;
        sin_pos = i_sin != '0;
    end

    // Footprint, box and corridor tests
    always_comb begin
        front_in = cos_pos && (p_cos < lff_pkg::FRONT_LIM_Q16);
        side_in  = sin_pos && (p_sin < lff_pkg::SIDE_LIM_Q16);
        box_in   = cos_pos && (p_cos < lff_pkg::BOX_LIM_Q16);
        masked   = valid && (i_region.front ? front_in : side_in);

        o_proj.filt = masked ? i_max_range : ld;
        priority if (i_region.box) begin
            o_proj.hit = box_in;
        end else if (i_region.corr) begin
            o_proj.hit = side_in && cos_pos;
        end else begin
            o_proj.hit = 1'b0;
        end

        // Rounded forward distance; cannot exceed 16 bits
        rnd         = {1'b0, p_cos} + (lff_pkg::PROD_W + 1)'(32768);
        o_proj.tod  = rnd[31:16];
        o_proj.last = i_region.last;
    end

endmodule

### rtl/core/lff_nearest.sv
`timescale 1ns / 1ps

module lff_nearest (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  lff_pkg::t_proj    i_proj,
    input  lff_pkg::t_mm      i_no_obstacle,
    output lff_pkg::t_mm      o_obstacle
);

    lff_pkg::t_mm r_nearest;
    logic         r_found;
    lff_pkg::t_mm n_nearest;
    logic         n_found;
    logic         upd;

    // Running minimum; zero counts as empty
    always_comb begin
        upd       = i_proj.hit &&
                    (!r_found || (r_nearest == '0) || (i_proj.tod < r_nearest));
        n_nearest = upd ? i_proj.tod : r_nearest;
        n_found   = r_found || upd;
        if (i_proj.last) begin
            o_obstacle = (n_found && (n_nearest != '0)) ? n_nearest : i_no_obstacle;
        end else begin
            o_obstacle = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nearest <= '0;
            r_found   <= 1'b0;
        end else if (i_take) begin
            if (i_proj.last) begin
                r_nearest <= '0;
                r_found   <= 1'b0;
            end else begin
                r_nearest <= n_nearest;
                r_found   <= n_found;
            end
        end
    end

endmodule

### rtl/core/lidar_footprint_filter_obstacle_dist_core.sv
`timescale 1ns / 1ps
// Lidar beam filter with trolley-footprint masking and forward obstacle distance.
// i_in carries one beam request per item (range_mm, range_bad); beams of a scan
// arrive in order, and an internal counter gives each beam's offset from the
// scan centre. o_out returns one result per beam: the filtered range, and on the
// last beam of a scan scan_end = 1 with the nearest forward obstacle distance
// (obstacle_mm is 0 on every other beam).
// A result passes the input register and then the output register on its way to o_out.
// One beam per cycle while o_out is ready. The path is two register stages: beam
// offset and trig ROM read into the input register, then footprint/box tests
// with two 16x17 multiplies and the running minimum into the output register.
// When o_out stalls, the stages fill up and i_in.ready drops once both are full;
// an empty input stage keeps taking a beam meanwhile.
// Reset empties the pipeline, restarts the beam counter and the minimum, and
// loads the register defaults (1024 beams, 25000, 50, 10000 mm).
// The user must write configuration (i_cfg_we/i_cfg_idx/i_cfg_wdata) only while no
// beam is in flight; the block itself does not enforce it.

module lidar_footprint_filter_obstacle_dist_core #(
    parameter int unsigned MAX_BEAMS     = 1024,
    parameter int unsigned FOOTPRINT_IDX = 170,
    parameter int unsigned BOX_EDGE_IDX  = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lff_in_if.sink             i_in,
    lff_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  lff_pkg::t_mm       i_cfg_wdata
);

    localparam int unsigned AW = $clog2(MAX_BEAMS);

    // Configuration registers
    lff_pkg::t_scan r_scan_beams;
    lff_pkg::t_mm   r_max_range;
    lff_pkg::t_mm   r_min_range;
    lff_pkg::t_mm   r_no_obstacle;

    // Pipeline control
    logic r_s1_vld;
    logic r_out_vld;
    logic out_free;
    logic s1_free;
    logic out_take;
    logic accept;

    // Stage payloads
    lff_pkg::t_mm     r_s1_raw;
    logic             r_s1_bad;
    lff_pkg::t_region r_s1_region;
    lff_pkg::t_mm     r_out_filt;
    lff_pkg::t_mm     r_out_obst;
    logic             r_out_end;

    logic [AW-1:0]    offset;
    lff_pkg::t_region region;
    lff_pkg::t_trig   s1_sin;
    lff_pkg::t_trig   s1_cos;
    lff_pkg::t_proj   proj;
    lff_pkg::t_mm     obstacle;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_beams  <= lff_pkg::RST_SCAN_BEAMS;
            r_max_range   <= lff_pkg::RST_MAX_RANGE;
            r_min_range   <= lff_pkg::RST_MIN_RANGE;
            r_no_obstacle <= lff_pkg::RST_NO_OBSTACLE;
        end else if (i_cfg_we) begin
            unique case (lff_pkg::t_cfg_idx'(i_cfg_idx))
                lff_pkg::CFG_SCAN_BEAMS:  r_scan_beams  <= i_cfg_wdata[lff_pkg::SCAN_W-1:0];
                lff_pkg::CFG_MAX_RANGE:   r_max_range   <= i_cfg_wdata;
                lff_pkg::CFG_MIN_RANGE:   r_min_range   <= i_cfg_wdata;
                lff_pkg::CFG_NO_OBSTACLE: r_no_obstacle <= i_cfg_wdata;
            endcase
        end
    end

    // Ready chain: a stage takes new data when empty or when it moves on
    always_comb begin
        out_free   = !r_out_vld || o_out.ready;
        s1_free    = !r_s1_vld || out_free;
        out_take   = r_s1_vld && out_free;
        i_in.ready = s1_free;
        accept     = i_in.valid && s1_free;
    end

    // Input stage: beam offset, region flags, ROM address
    lff_beam_index #(
        .MAX_BEAMS     (MAX_BEAMS),
        .FOOTPRINT_IDX (FOOTPRINT_IDX),
        .BOX_EDGE_IDX  (BOX_EDGE_IDX)
    ) u_beam_index (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_scan_beams (r_scan_beams),
        .o_offset     (offset),
        .o_region     (region)
    );

    lff_trig_rom #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_trig_rom (
        .i_clk  (i_clk),
        .i_en   (accept),
        .i_addr (offset),
        .o_sin  (s1_sin),
        .o_cos  (s1_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_raw    <= i_in.range_mm;
            r_s1_bad    <= i_in.range_bad;
            r_s1_region <= region;
        end
    end

    // Validity, footprint mask, projections
    lff_mask_proj u_mask_proj (
        .i_raw       (r_s1_raw),
        .i_bad       (r_s1_bad),
        .i_region    (r_s1_region),
        .i_sin       (s1_sin),
        .i_cos       (s1_cos),
        .i_max_range (r_max_range),
        .i_min_range (r_min_range),
        .o_proj      (proj)
    );

    // Running minimum and output register
    lff_nearest u_nearest (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (out_take),
        .i_proj        (proj),
        .i_no_obstacle (r_no_obstacle),
        .o_obstacle    (obstacle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out_filt <= proj.filt;
            r_out_obst <= obstacle;
            r_out_end  <= proj.last;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.filtered_mm = r_out_filt;
    assign o_out.obstacle_mm = r_out_obst;
    assign o_out.scan_end    = r_out_end;

    // Checks
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_s1_vld && !r_out_vld)
        else $error("pipeline not empty after reset");

    a_mid_scan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.scan_end |-> o_out.obstacle_mm == '0)
        else $error("obstacle distance on a beam that is not the last");

    a_bubble_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_vld |-> i_in.ready)
        else $error("input stalled with an empty first stage");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take |=> r_out_vld)
        else $error("request lost on its way to the output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.filtered_mm)
            && $stable(o_out.obstacle_mm) && $stable(o_out.scan_end))
        else $error("result changed while stalled");

endmodule

### test/lidar_footprint_filter_obstacle_dist_core_test.sv
`timescale 1ns / 1ps

module lidar_footprint_filter_obstacle_dist_core_test;

    localparam int unsigned MAX_BEAMS     = 1024;
    localparam int unsigned FOOTPRINT_IDX = 170;
    localparam int unsigned BOX_EDGE_IDX  = 30;
    localparam int unsigned RANDOM_BEAMS  = 1700;

    // One filtered beam as it leaves the block
    typedef struct packed {
        lff_pkg::t_mm filtered;
        lff_pkg::t_mm obstacle;
        logic         scan_end;
    } t_beam_result;

    typedef enum bit {ROW_REG, ROW_BEAM} t_row_kind;

    // Directed stimulus row: a register write or a beam request
    typedef struct packed {
        t_row_kind         kind;
        lff_pkg::t_cfg_idx idx;
        lff_pkg::t_mm      val;
        lff_pkg::t_mm      rng;
        logic              bad;
        logic              typed;
        t_beam_result      want;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_idx;
    lff_pkg::t_mm cfg_wdata;

    lff_in_if  beam_in ();
    lff_out_if beam_out ();

    lidar_footprint_filter_obstacle_dist_core #(
        .MAX_BEAMS     (MAX_BEAMS),
        .FOOTPRINT_IDX (FOOTPRINT_IDX),
        .BOX_EDGE_IDX  (BOX_EDGE_IDX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (beam_in),
        .o_out       (beam_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the registers and the scan state
    lff_pkg::t_scan scan_beams_reg  = lff_pkg::RST_SCAN_BEAMS;
    lff_pkg::t_mm   max_range_reg   = lff_pkg::RST_MAX_RANGE;
    lff_pkg::t_mm   min_range_reg   = lff_pkg::RST_MIN_RANGE;
    lff_pkg::t_mm   no_obstacle_reg = lff_pkg::RST_NO_OBSTACLE;
    int unsigned    beam_idx        = 0;
    int unsigned    nearest_reg     = 0;
    bit             seen_hit        = 0;

    t_beam_result beam_results_due[$];
    t_row         directed_rows[$];

    int fail_count      = 0;
    int results_checked = 0;
    int scan_ends       = 0;
    int obstacles_found = 0;
    int beams_sent      = 0;
    int burst_left      = 0;

    // sin of a Q30 angle in Q16: fold to the first quadrant, Taylor series to x^13
    function automatic int q16_sine(input longint unsigned ang);
        longint unsigned a;
        longint unsigned x;
        longint unsigned term;
        longint unsigned s;
        longint          sum;
        bit              flip;
        a    = ang % lff_pkg::TWO_PI_Q30;
        flip = (a >= lff_pkg::PI_Q30);
        if (flip) begin
            a = a - lff_pkg::PI_Q30;
        end
        if (a > lff_pkg::HALF_PI_Q30) begin
            a = lff_pkg::PI_Q30 - a;
        end
        x    = a;
        term = a;
        sum  = longint'(a);
        for (int k = 1; k <= 6; k++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        s = (unsigned'(sum) + 64'd8192) >> 14;
        if (s > 64'd65536) begin
            s = 64'd65536;
        end
        return flip ? -int'(s) : int'(s);
    endfunction

    // ld * trig below a Q16 limit; never met for a non-positive trig value
    function automatic bit under_limit(input int unsigned ld, input int t,
                                       input lff_pkg::t_prod lim);
        if (t <= 0) begin
            return 1'b0;
        end
        return (longint'(ld) * longint'(t)) < longint'(lim);
    endfunction

    // Filter one beam and advance the scan state
    function automatic t_beam_result filter_beam(input lff_pkg::t_mm raw, input logic bad);
        t_beam_result res;
        int unsigned  n;
        int unsigned  c;
        int unsigned  d;
        int unsigned  ld;
        int unsigned  tod;
        bit           lower;
        bit           ok;
        bit           masked;
        bit           hit;
        int           sn;
        int           cs;
        n = scan_beams_reg;
        if (n < 2) begin
            n = 2;
        end
        if (n > MAX_BEAMS) begin
            n = MAX_BEAMS;
        end
        c     = n / 2;
        lower = beam_idx < c;
        d     = lower ? c - beam_idx : beam_idx - c;
        sn    = q16_sine(64'(d) * lff_pkg::STEP_Q30);
        cs    = q16_sine(64'(d) * lff_pkg::STEP_Q30 + lff_pkg::HALF_PI_Q30);

        ok = !bad && raw <= max_range_reg && raw >= min_range_reg;
        ld = ok ? raw : max_range_reg;

        // footprint mask: front edge near the centre, side edge further out
        masked = 1'b0;
        if (ok) begin
            if (lower ? (d <= FOOTPRINT_IDX) : (d < FOOTPRINT_IDX)) begin
                masked = under_limit(ld, cs, lff_pkg::FRONT_LIM_Q16);
            end else begin
                masked = under_limit(ld, sn, lff_pkg::SIDE_LIM_Q16);
            end
        end

        // forward box, then side corridor
        hit = 1'b0;
        if (lower ? (d < BOX_EDGE_IDX) : (d <= BOX_EDGE_IDX)) begin
            hit = under_limit(ld, cs, lff_pkg::BOX_LIM_Q16);
        end else if (d <= FOOTPRINT_IDX) begin
            hit = under_limit(ld, sn, lff_pkg::SIDE_LIM_Q16) && cs > 0;
        end
        if (hit) begin
            tod = 32'((longint'(ld) * longint'(cs) + 32768) >> 16);
            if (!seen_hit || nearest_reg == 0 || tod < nearest_reg) begin
                nearest_reg = tod;
                seen_hit    = 1'b1;
            end
        end

        res.filtered = masked ? max_range_reg : lff_pkg::t_mm'(ld);
        res.obstacle = '0;
        res.scan_end = beam_idx >= n - 1;
        if (res.scan_end) begin
            if (seen_hit && nearest_reg != 0) begin
                res.obstacle = lff_pkg::t_mm'(nearest_reg);
                obstacles_found++;
            end else begin
                res.obstacle = no_obstacle_reg;
            end
            beam_idx    = 0;
            nearest_reg = 0;
            seen_hit    = 1'b0;
        end else begin
            beam_idx = beam_idx + 1;
        end
        return res;
    endfunction

    function automatic void add_reg_row(input lff_pkg::t_cfg_idx idx, input lff_pkg::t_mm val);
        t_row r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.val  = val;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_beam_row(input lff_pkg::t_mm rng, input logic bad);
        t_row r;
        r      = '0;
        r.kind = ROW_BEAM;
        r.rng  = rng;
        r.bad  = bad;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_known_row(input lff_pkg::t_mm rng, input logic bad,
                                          input lff_pkg::t_mm filt, input lff_pkg::t_mm obst,
                                          input logic last);
        t_row r;
        r               = '0;
        r.kind          = ROW_BEAM;
        r.rng           = rng;
        r.bad           = bad;
        r.typed         = 1'b1;
        r.want.filtered = filt;
        r.want.obstacle = obst;
        r.want.scan_end = last;
        directed_rows.push_back(r);
    endfunction

    // Present one beam request, honoring the burst/gap pattern
    task automatic send_beam(input lff_pkg::t_mm rng, input logic bad, input logic typed,
                             input t_beam_result want);
        t_beam_result predicted;
        int           gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            beam_in.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 300)
                                                     : $urandom_range(1, 24);
        end
        @(negedge i_clk);
        beam_in.valid     <= 1'b1;
        beam_in.range_mm  <= rng;
        beam_in.range_bad <= bad;
        @(posedge i_clk);
        while (beam_in.ready !== 1'b1) @(posedge i_clk);
        predicted = filter_beam(rng, bad);
        beam_results_due.push_back(typed ? want : predicted);
        burst_left--;
        beams_sent++;
    endtask

    // Drop valid and wait for the pipeline to empty
    task automatic settle();
        @(negedge i_clk);
        beam_in.valid <= 1'b0;
        while (beam_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input lff_pkg::t_cfg_idx idx, input lff_pkg::t_mm val);
        settle();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        case (idx)
            lff_pkg::CFG_SCAN_BEAMS:  scan_beams_reg  = val[lff_pkg::SCAN_W-1:0];
            lff_pkg::CFG_MAX_RANGE:   max_range_reg   = val;
            lff_pkg::CFG_MIN_RANGE:   min_range_reg   = val;
            lff_pkg::CFG_NO_OBSTACLE: no_obstacle_reg = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_beam_result want;
        t_beam_result got;
        if (i_rst_n === 1'b1 && beam_out.valid === 1'b1 && beam_out.ready === 1'b1) begin
            got.filtered = beam_out.filtered_mm;
            got.obstacle = beam_out.obstacle_mm;
            got.scan_end = beam_out.scan_end;
            if (beam_results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: unexpected result filt=%0d obst=%0d end=%0b", $time,
                             got.filtered, got.obstacle, got.scan_end);
                end
            end else begin
                want = beam_results_due.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display({"%0t: result %0d filt exp %0d got %0d, ",
                                  "obst exp %0d got %0d, end exp %0b got %0b"},
                                 $time, results_checked, want.filtered, got.filtered,
                                 want.obstacle, got.obstacle, want.scan_end, got.scan_end);
                    end
                end
                if (want.scan_end) begin
                    scan_ends++;
                end
            end
            results_checked++;
        end
    end

    // Output stall patterns
    initial begin : out_stall
        int mode;
        int span;
        int k;
        beam_out.ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            k    = $urandom_range(2, 5);
            for (int tick = 0; tick < span; tick++) begin
                @(negedge i_clk);
                case (mode)
                    0:       beam_out.ready <= 1'b1;
                    1:       beam_out.ready <= 1'($urandom_range(0, 1));
                    2:       beam_out.ready <= (tick % k) != 0;
                    default: beam_out.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("lidar_footprint_filter_obstacle_dist_core_test NOT OK");
        $finish;
    end

    initial begin
        t_row           r;
        t_beam_result   none;
        lff_pkg::t_mm   rng;
        logic           bad;
        longint         near;
        int unsigned    n_eff;
        int             phase_beams;
        int             directed_beams;
        int             random_beams;
        int             phases;
        lff_pkg::t_scan scan_val;

        i_rst_n           = 1'b0;
        beam_in.valid     = 1'b0;
        beam_in.range_mm  = '0;
        beam_in.range_bad = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = lff_pkg::CFG_SCAN_BEAMS;
        cfg_wdata         = '0;
        none              = '0;
        random_beams      = 0;
        phases            = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Two-beam scans: first beam one step off centre, second on centre
        add_reg_row(lff_pkg::CFG_SCAN_BEAMS, 16'd2);
        add_known_row(16'd3000, 1'b0, 16'd3000, 16'd0, 1'b0);
        add_known_row(16'd1000, 1'b0, 16'd1000, 16'd1000, 1'b1);
        // bad, too far, too near, at both limits
        add_known_row(16'd0, 1'b1, 16'd25000, 16'd0, 1'b0);
        add_known_row(16'd65535, 1'b0, 16'd25000, 16'd10000, 1'b1);
        add_known_row(16'd49, 1'b0, 16'd25000, 16'd0, 1'b0);
        add_known_row(16'd50, 1'b0, 16'd25000, 16'd50, 1'b1);
        add_known_row(16'd25000, 1'b0, 16'd25000, 16'd0, 1'b0);
        add_known_row(16'd265, 1'b0, 16'd25000, 16'd265, 1'b1);
        // front gap and box reach edges
        add_beam_row(16'd2266, 1'b0);
        add_beam_row(16'd2266, 1'b0);
        add_beam_row(16'd266, 1'b0);
        add_beam_row(16'd2265, 1'b0);
        // a zero minimum counts as empty
        add_reg_row(lff_pkg::CFG_MIN_RANGE, 16'd0);
        add_known_row(16'd0, 1'b0, 16'd25000, 16'd0, 1'b0);
        add_known_row(16'd30000, 1'b0, 16'd25000, 16'd10000, 1'b1);
        add_known_row(16'd0, 1'b0, 16'd25000, 16'd0, 1'b0);
        add_known_row(16'd500, 1'b0, 16'd500, 16'd500, 1'b1);
        // min above max: nothing is valid
        add_reg_row(lff_pkg::CFG_MAX_RANGE, 16'd20000);
        add_reg_row(lff_pkg::CFG_MIN_RANGE, 16'd30000);
        add_known_row(16'd25000, 1'b0, 16'd20000, 16'd0, 1'b0);
        add_known_row(16'd1000, 1'b0, 16'd20000, 16'd10000, 1'b1);
        // zero max range, largest default
        add_reg_row(lff_pkg::CFG_MAX_RANGE, 16'd0);
        add_reg_row(lff_pkg::CFG_MIN_RANGE, 16'd0);
        add_reg_row(lff_pkg::CFG_NO_OBSTACLE, 16'd65535);
        add_known_row(16'd0, 1'b0, 16'd0, 16'd0, 1'b0);
        add_known_row(16'd0, 1'b0, 16'd0, 16'd65535, 1'b1);
        add_known_row(16'd65535, 1'b1, 16'd0, 16'd0, 1'b0);
        add_known_row(16'd65535, 1'b0, 16'd0, 16'd65535, 1'b1);
        // full-scale max range
        add_reg_row(lff_pkg::CFG_MAX_RANGE, 16'd65535);
        add_known_row(16'd65535, 1'b0, 16'd65535, 16'd0, 1'b0);
        add_known_row(16'd65535, 1'b0, 16'd65535, 16'd65535, 1'b1);
        // scan length below range clamps to two
        add_reg_row(lff_pkg::CFG_SCAN_BEAMS, 16'd0);
        add_beam_row(16'd1200, 1'b0);
        add_beam_row(16'd0, 1'b1);

        foreach (directed_rows[j]) begin
            r = directed_rows[j];
            if (r.kind == ROW_REG) begin
                write_reg(r.idx, r.val);
            end else begin
                send_beam(r.rng, r.bad, r.typed, r.want);
            end
        end
        directed_beams = beams_sent;

        // Random phases, each with its own register setting
        while (random_beams < RANDOM_BEAMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 5))
                        0:       scan_val = 11'd0;
                        1:       scan_val = 11'd1;
                        2:       scan_val = 11'd2;
                        3:       scan_val = 11'd1024;
                        4:       scan_val = 11'd1025;
                        default: scan_val = 11'd2047;
                    endcase
                end
                1, 2, 3: scan_val = lff_pkg::t_scan'($urandom_range(2, 16));
                4, 5, 6: scan_val = lff_pkg::t_scan'($urandom_range(17, 200));
                default: scan_val = lff_pkg::t_scan'($urandom_range(342, 420));
            endcase
            write_reg(lff_pkg::CFG_SCAN_BEAMS, lff_pkg::t_mm'(scan_val));
            case ($urandom_range(0, 9))
                0:       write_reg(lff_pkg::CFG_MAX_RANGE,
                                   $urandom_range(0, 1) ? 16'd65535 : 16'd0);
                1:       write_reg(lff_pkg::CFG_MAX_RANGE, lff_pkg::t_mm'($urandom));
                2, 3:    write_reg(lff_pkg::CFG_MAX_RANGE, lff_pkg::RST_MAX_RANGE);
                default: write_reg(lff_pkg::CFG_MAX_RANGE,
                                   lff_pkg::t_mm'($urandom_range(3000, 30000)));
            endcase
            case ($urandom_range(0, 9))
                0:       write_reg(lff_pkg::CFG_MIN_RANGE, 16'd0);
                1:       write_reg(lff_pkg::CFG_MIN_RANGE, 16'd65535);
                2:       write_reg(lff_pkg::CFG_MIN_RANGE, lff_pkg::t_mm'($urandom));
                3, 4:    write_reg(lff_pkg::CFG_MIN_RANGE, lff_pkg::RST_MIN_RANGE);
                default: write_reg(lff_pkg::CFG_MIN_RANGE,
                                   lff_pkg::t_mm'($urandom_range(0, 300)));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(lff_pkg::CFG_NO_OBSTACLE, 16'd0);
                1:       write_reg(lff_pkg::CFG_NO_OBSTACLE, 16'd65535);
                default: write_reg(lff_pkg::CFG_NO_OBSTACLE, lff_pkg::t_mm'($urandom));
            endcase
            phases++;

            n_eff = scan_val;
            if (n_eff < 2) begin
                n_eff = 2;
            end
            if (n_eff > MAX_BEAMS) begin
                n_eff = MAX_BEAMS;
            end
            // large scans may stop part way; the next setting then ends them early
            if (n_eff <= 200) begin
                phase_beams = $urandom_range(60, 200);
            end else if (n_eff < MAX_BEAMS) begin
                phase_beams = $urandom_range(n_eff / 2, n_eff + 60);
            end else begin
                phase_beams = $urandom_range(100, 300);
            end

            for (int b = 0; b < phase_beams && random_beams < RANDOM_BEAMS; b++) begin
                bad = 1'b0;
                case ($urandom_range(0, 9))
                    0: begin
                        rng = lff_pkg::t_mm'($urandom);
                        bad = 1'b1;
                    end
                    1:       rng = lff_pkg::t_mm'($urandom);
                    2, 3, 4: rng = lff_pkg::t_mm'($urandom_range(0, 2400));
                    5, 6: begin
                        // near a register limit or a geometry edge
                        case ($urandom_range(0, 4))
                            0:       near = max_range_reg;
                            1:       near = min_range_reg;
                            2:       near = 266;
                            3:       near = 400;
                            default: near = 2266;
                        endcase
                        near = near + longint'($urandom_range(0, 40)) - 20;
                        if (near < 0) begin
                            near = 0;
                        end
                        if (near > 65535) begin
                            near = 65535;
                        end
                        rng = lff_pkg::t_mm'(near);
                    end
                    default: rng = lff_pkg::t_mm'($urandom_range(0, max_range_reg));
                endcase
                send_beam(rng, bad, 1'b0, none);
                random_beams++;
            end
        end

        // Drain
        @(negedge i_clk);
        beam_in.valid <= 1'b0;
        for (int w = 0; w < 5000 && beam_results_due.size() != 0; w++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (beam_results_due.size() != 0) begin
            fail_count += beam_results_due.size();
            $display("%0d expected results never arrived", beam_results_due.size());
        end

        $display("Sent %0d beams (%0d directed) over %0d random register settings.",
                 beams_sent, directed_beams, phases);
        $display("Compared %0d results, %0d scan ends, %0d with an obstacle; %0d mismatches.",
                 results_checked, scan_ends, obstacles_found, fail_count);
        if (fail_count == 0) begin
            $display("lidar_footprint_filter_obstacle_dist_core_test OK");
        end else begin
            $display("lidar_footprint_filter_obstacle_dist_core_test NOT OK");
        end
        $finish;
    end

endmodule

### lidar_footprint_filter_obstacle_dist_core.f
rtl/core/lff_pkg.sv
rtl/core/lff_in_if.sv
rtl/core/lff_out_if.sv
rtl/core/lff_beam_index.sv
rtl/core/lff_trig_rom.sv
rtl/core/lff_mask_proj.sv
rtl/core/lff_nearest.sv
rtl/core/lidar_footprint_filter_obstacle_dist_core.sv
test/lidar_footprint_filter_obstacle_dist_core_test.sv
